FILE: rtl/core/sfg_pkg.sv
// Shared types, constants and helper functions of the spotlight falloff texel generator.
// Used by every module under rtl/core; depends on nothing else.
package sfg_pkg;

  localparam int MAX_SIZE     = 1024;
  localparam int DEFAULT_SIZE = 64;

  typedef enum logic [2:0] {
    REG_IMAGE_SIZE = 3'd0,
    REG_EDGE_RADIUS = 3'd1,
    REG_FALLOFF_EXP = 3'd2,
    REG_RED_LEVEL = 3'd3,
    REG_GREEN_LEVEL = 3'd4,
    REG_BLUE_LEVEL = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [10:0] image_size;
    logic [16:0] edge_radius;
    logic [15:0] falloff_exponent;
    logic [15:0] red_level;
    logic [15:0] green_level;
    logic [15:0] blue_level;
  } cfg_t;

  typedef struct packed {
    logic [8:0] octant_col;
    logic [8:0] octant_row;
  } in_item_t;

  typedef struct packed {
    logic [9:0] texel_col;
    logic [9:0] texel_row;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       last_write;
  } out_item_t;

  typedef struct packed {
    in_item_t   coord;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } core_res_t;

  function automatic logic [10:0] eff_size(input logic [10:0] size_reg);
    logic [10:0] res;
    if (size_reg == '0) begin
      res = 11'(DEFAULT_SIZE);
    end else if (size_reg > 11'(MAX_SIZE)) begin
      res = 11'(MAX_SIZE);
    end else begin
      res = size_reg;
    end
    return res;
  endfunction

  function automatic logic [9:0] half_span(input logic [10:0] size);
    logic [10:0] diff;
    diff = size - 11'd2;
    return (size >= 11'd2) ? diff[10:1] : '0;
  endfunction

endpackage

FILE: rtl/core/sfg_cfg.sv
// APB-style register file holding the light and texture settings.
// Depends on sfg_pkg for the register map and the settings struct.
module sfg_cfg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output sfg_pkg::cfg_t     cfg_o
);

  sfg_pkg::cfg_t     cfg_q, cfg_d;
  sfg_pkg::reg_idx_e idx;
  logic              wr_en;

  assign idx    = sfg_pkg::reg_idx_e'(paddr[4:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        sfg_pkg::REG_IMAGE_SIZE:  cfg_d.image_size       = pwdata[10:0];
        sfg_pkg::REG_EDGE_RADIUS: cfg_d.edge_radius      = pwdata[16:0];
        sfg_pkg::REG_FALLOFF_EXP: cfg_d.falloff_exponent = pwdata[15:0];
        sfg_pkg::REG_RED_LEVEL:   cfg_d.red_level        = pwdata[15:0];
        sfg_pkg::REG_GREEN_LEVEL: cfg_d.green_level      = pwdata[15:0];
        sfg_pkg::REG_BLUE_LEVEL:  cfg_d.blue_level       = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      sfg_pkg::REG_IMAGE_SIZE:  prdata = {21'b0, cfg_q.image_size};
      sfg_pkg::REG_EDGE_RADIUS: prdata = {15'b0, cfg_q.edge_radius};
      sfg_pkg::REG_FALLOFF_EXP: prdata = {16'b0, cfg_q.falloff_exponent};
      sfg_pkg::REG_RED_LEVEL:   prdata = {16'b0, cfg_q.red_level};
      sfg_pkg::REG_GREEN_LEVEL: prdata = {16'b0, cfg_q.green_level};
      sfg_pkg::REG_BLUE_LEVEL:  prdata = {16'b0, cfg_q.blue_level};
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_size       <= 11'd64;
      cfg_q.edge_radius      <= '0;
      cfg_q.falloff_exponent <= 16'd256;
      cfg_q.red_level        <= 16'hFFFF;
      cfg_q.green_level      <= 16'hFFFF;
      cfg_q.blue_level       <= 16'hFFFF;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

FILE: rtl/core/sfg_core.sv
// Intensity pipeline: distance by division and square root, cosine falloff, power and color.
// Depends on sfg_pkg; all stages advance together on en_i.
module sfg_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  sfg_pkg::in_item_t  item_i,
  input  sfg_pkg::cfg_t      cfg_i,
  output logic               valid_o,
  output sfg_pkg::core_res_t res_o
);

  localparam int D1_STAGES = 9;
  localparam int D1_STEPS  = 4;
  localparam int SQ_STAGES = 6;
  localparam int SQ_STEPS  = 3;
  localparam int D2_STAGES = 4;
  localparam int D2_STEPS  = 4;
  localparam int COS_TERMS = 5;
  localparam int LOG_STEPS = 16;
  localparam int SER_TERMS = 9;
  localparam int NTOT = 1 + D1_STAGES + SQ_STAGES + 1 + D2_STAGES + 1 + 2 * COS_TERMS
                      + 1 + LOG_STEPS + 2 + 3 * SER_TERMS + 3;

  localparam logic [30:0] COS_A10 = 31'd27060;
  localparam logic [30:0] COS_COEF [COS_TERMS] =
    '{31'd987048, 31'd22401992, 31'd272375560, 31'd1324675879, 31'd1073741824};
  localparam logic [29:0] LN2_Q30 = 30'd744261118;
  localparam logic [31:0] ONE_Q30 = 32'd1073741824;
  localparam logic [31:0] SER_DIV [SER_TERMS] =
    '{32'd9, 32'd8, 32'd7, 32'd6, 32'd5, 32'd4, 32'd3, 32'd2, 32'd1};
  localparam logic [31:0] SER_RECIP [SER_TERMS] =
    '{32'd477218588, 32'd536870911, 32'd613566756, 32'd715827882, 32'd858993459,
      32'd1073741823, 32'd1431655765, 32'd2147483647, 32'd4294967295};

  typedef enum logic [1:0] {
    CLS_FULL = 2'd0,
    CLS_FALL = 2'd1,
    CLS_ZERO = 2'd2
  } cls_e;

  typedef struct packed {
    logic [18:0] s;
    logic [17:0] hsq;
  } ent_t;

  typedef struct packed {
    logic [17:0] rem;
    logic [35:0] num;
    logic [35:0] quo;
    logic [17:0] den;
  } d1_t;

  typedef struct packed {
    logic [18:0] rem;
    logic [17:0] root;
    logic [35:0] rad;
  } sq_t;

  typedef struct packed {
    cls_e        cls;
    logic [15:0] num;
    logic [16:0] den;
  } cl_t;

  typedef struct packed {
    cls_e        cls;
    logic [17:0] rem;
    logic [15:0] quo;
    logic [17:0] den;
  } d2_t;

  typedef struct packed {
    cls_e        cls;
    logic [29:0] z;
    logic [60:0] prod;
  } cm_t;

  typedef struct packed {
    cls_e        cls;
    logic [29:0] z;
    logic [30:0] p;
  } cs_t;

  typedef struct packed {
    cls_e        cls;
    logic [16:0] x;
    logic [15:0] f;
    logic [4:0]  k;
  } lgs_t;

  typedef struct packed {
    cls_e        cls;
    logic [28:0] prod;
  } pr_t;

  typedef struct packed {
    cls_e        cls;
    logic [29:0] w;
    logic [4:0]  n;
    logic [31:0] p;
  } sa_t;

  typedef struct packed {
    cls_e        cls;
    logic [29:0] w;
    logic [4:0]  n;
    logic [61:0] wp;
  } sm_t;

  typedef struct packed {
    cls_e        cls;
    logic [29:0] w;
    logic [4:0]  n;
    logic [31:0] v;
    logic [63:0] mq;
  } sr_t;

  function automatic logic [18:0] div_step(input logic [17:0] rem, input logic bit_in,
                                           input logic [17:0] den);
    logic [18:0] rem2;
    logic [18:0] diff;
    rem2 = {rem, bit_in};
    diff = rem2 - {1'b0, den};
    return (rem2 >= {1'b0, den}) ? {1'b1, diff[17:0]} : {1'b0, rem2[17:0]};
  endfunction

  logic [NTOT-1:0]   v_q;
  sfg_pkg::in_item_t xy_q [NTOT];
  logic              entry_ok;

  ent_t ent_q, ent_d;
  d1_t  d1_q [D1_STAGES];
  d1_t  d1_d [D1_STAGES];
  sq_t  sq_q [SQ_STAGES];
  sq_t  sq_d [SQ_STAGES];
  cl_t  cl_q, cl_d;
  d2_t  d2_q [D2_STAGES];
  d2_t  d2_d [D2_STAGES];
  cm_t  cm_q [COS_TERMS];
  cm_t  cm_d [COS_TERMS];
  cs_t  cs_q [COS_TERMS+1];
  cs_t  cs_d [COS_TERMS+1];
  lgs_t lgs_q [LOG_STEPS+1];
  lgs_t lgs_d [LOG_STEPS+1];
  pr_t  pr_q, pr_d;
  sm_t  sm_q [SER_TERMS];
  sm_t  sm_d [SER_TERMS];
  sr_t  sr_q [SER_TERMS];
  sr_t  sr_d [SER_TERMS];
  sa_t  sa_q [SER_TERMS+1];
  sa_t  sa_d [SER_TERMS+1];
  logic [16:0] inten_q, inten_d;
  logic [32:0] lvl_q [3];
  logic [32:0] lvl_d [3];
  logic [7:0]  rgb_q [3];
  logic [7:0]  rgb_d [3];

  always_comb begin
    logic [10:0] size;
    logic [9:0]  hw;
    logic [9:0]  xp1;
    logic [9:0]  yp2;
    logic [19:0] sq_x;
    logic [19:0] sq_y;
    logic [19:0] hsq;
    logic [19:0] ssum;
    size  = sfg_pkg::eff_size(cfg_i.image_size);
    hw    = sfg_pkg::half_span(size);
    xp1   = {1'b0, item_i.octant_col} + 10'd1;
    yp2   = {1'b0, item_i.octant_row} + 10'd2;
    sq_x  = xp1 * xp1;
    sq_y  = yp2 * yp2;
    hsq   = hw * hw;
    ssum  = sq_x + sq_y;
    ent_d.s   = ssum[18:0];
    ent_d.hsq = hsq[17:0];
    entry_ok  = (hw != '0) && (item_i.octant_row <= item_i.octant_col)
                && ({1'b0, item_i.octant_col} < hw);
  end

  always_comb begin
    d1_t         cur;
    logic [18:0] st;
    for (int i = 0; i < D1_STAGES; i++) begin
      if (i == 0) begin
        cur.rem = {3'b0, ent_q.s[18:4]};
        cur.num = {ent_q.s[3:0], 32'b0};
        cur.quo = '0;
        cur.den = ent_q.hsq;
      end else begin
        cur = d1_q[i-1];
      end
      for (int j = 0; j < D1_STEPS; j++) begin
        st      = div_step(cur.rem, cur.num[35], cur.den);
        cur.rem = st[17:0];
        cur.quo = {cur.quo[34:0], st[18]};
        cur.num = {cur.num[34:0], 1'b0};
      end
      d1_d[i] = cur;
    end
  end

  always_comb begin
    sq_t         cur;
    logic [20:0] rem2;
    logic [19:0] trial;
    logic [20:0] diff;
    for (int i = 0; i < SQ_STAGES; i++) begin
      if (i == 0) begin
        cur.rem  = '0;
        cur.root = '0;
        cur.rad  = d1_q[D1_STAGES-1].quo;
      end else begin
        cur = sq_q[i-1];
      end
      for (int j = 0; j < SQ_STEPS; j++) begin
        rem2  = {cur.rem, cur.rad[35:34]};
        trial = {cur.root, 2'b01};
        diff  = rem2 - {1'b0, trial};
        if (rem2 >= {1'b0, trial}) begin
          cur.rem  = diff[18:0];
          cur.root = {cur.root[16:0], 1'b1};
        end else begin
          cur.rem  = rem2[18:0];
          cur.root = {cur.root[16:0], 1'b0};
        end
        cur.rad = {cur.rad[33:0], 2'b00};
      end
      sq_d[i] = cur;
    end
  end

  always_comb begin
    logic [17:0] d;
    logic [17:0] num;
    logic [17:0] den;
    d   = sq_q[SQ_STAGES-1].root;
    num = d - {1'b0, cfg_i.edge_radius};
    den = 18'h10000 - {1'b0, cfg_i.edge_radius};
    if ({1'b0, cfg_i.edge_radius} >= d) begin
      cl_d.cls = CLS_FULL;
    end else if (d[17:16] == 2'b00) begin
      cl_d.cls = CLS_FALL;
    end else begin
      cl_d.cls = CLS_ZERO;
    end
    cl_d.num = num[15:0];
    cl_d.den = den[16:0];
  end

  always_comb begin
    d2_t         cur;
    logic [18:0] st;
    for (int i = 0; i < D2_STAGES; i++) begin
      if (i == 0) begin
        cur.cls = cl_q.cls;
        cur.rem = {2'b0, cl_q.num};
        cur.quo = '0;
        cur.den = {1'b0, cl_q.den};
      end else begin
        cur = d2_q[i-1];
      end
      for (int j = 0; j < D2_STEPS; j++) begin
        st      = div_step(cur.rem, 1'b0, cur.den);
        cur.rem = st[17:0];
        cur.quo = {cur.quo[14:0], st[18]};
      end
      d2_d[i] = cur;
    end
  end

  always_comb begin
    logic [31:0] tt;
    logic [30:0] hi;
    tt           = d2_q[D2_STAGES-1].quo * d2_q[D2_STAGES-1].quo;
    cs_d[0].cls  = d2_q[D2_STAGES-1].cls;
    cs_d[0].z    = tt[31:2];
    cs_d[0].p    = COS_A10;
    for (int k = 0; k < COS_TERMS; k++) begin
      cm_d[k].cls    = cs_q[k].cls;
      cm_d[k].z      = cs_q[k].z;
      cm_d[k].prod   = cs_q[k].z * cs_q[k].p;
      hi             = cm_q[k].prod[60:30];
      cs_d[k+1].cls  = cm_q[k].cls;
      cs_d[k+1].z    = cm_q[k].z;
      cs_d[k+1].p    = (COS_COEF[k] > hi) ? (COS_COEF[k] - hi) : '0;
    end
  end

  always_comb begin
    logic [16:0] c;
    logic [4:0]  k;
    logic [33:0] sqr;
    c = cs_q[COS_TERMS].p[30:14];
    k = '0;
    for (int j = 0; j < 16; j++) begin
      if (c[j]) begin
        k = 5'(16 - j);
      end
    end
    lgs_d[0].cls = cs_q[COS_TERMS].cls;
    if (cs_q[COS_TERMS].cls == CLS_FALL) begin
      if ((cfg_i.falloff_exponent == '0) || c[16]) begin
        lgs_d[0].cls = CLS_FULL;
      end else if (c[15:0] == '0) begin
        lgs_d[0].cls = CLS_ZERO;
      end
    end
    lgs_d[0].x = 17'({1'b0, c[15:0]} << k);
    lgs_d[0].f = '0;
    lgs_d[0].k = k;
    for (int s = 1; s <= LOG_STEPS; s++) begin
      sqr          = lgs_q[s-1].x * lgs_q[s-1].x;
      lgs_d[s].cls = lgs_q[s-1].cls;
      lgs_d[s].k   = lgs_q[s-1].k;
      if (sqr[33]) begin
        lgs_d[s].x = sqr[33:17];
        lgs_d[s].f = {lgs_q[s-1].f[14:0], 1'b1};
      end else begin
        lgs_d[s].x = sqr[32:16];
        lgs_d[s].f = {lgs_q[s-1].f[14:0], 1'b0};
      end
    end
  end

  always_comb begin
    logic [20:0] lg;
    logic [36:0] prod;
    lg        = {lgs_q[LOG_STEPS].k, 16'b0} - {5'b0, lgs_q[LOG_STEPS].f};
    prod      = cfg_i.falloff_exponent * lg;
    pr_d.cls  = lgs_q[LOG_STEPS].cls;
    pr_d.prod = prod[36:8];
  end

  always_comb begin
    logic [16:0] om;
    logic [46:0] wf;
    logic [31:0] q0;
    logic [31:0] qi;
    logic [31:0] rr;
    logic [31:0] q;
    om = 17'h10000 - {1'b0, pr_q.prod[15:0]};
    wf = om * LN2_Q30;
    sa_d[0].cls = pr_q.cls;
    if ((pr_q.cls == CLS_FALL) && (pr_q.prod[28:16] > 13'd16)) begin
      sa_d[0].cls = CLS_ZERO;
    end
    sa_d[0].w = wf[45:16];
    sa_d[0].n = pr_q.prod[20:16];
    sa_d[0].p = ONE_Q30;
    for (int j = 0; j < SER_TERMS; j++) begin
      sm_d[j].cls = sa_q[j].cls;
      sm_d[j].w   = sa_q[j].w;
      sm_d[j].n   = sa_q[j].n;
      sm_d[j].wp  = sa_q[j].w * sa_q[j].p;
      sr_d[j].cls = sm_q[j].cls;
      sr_d[j].w   = sm_q[j].w;
      sr_d[j].n   = sm_q[j].n;
      sr_d[j].v   = sm_q[j].wp[61:30];
      sr_d[j].mq  = sm_q[j].wp[61:30] * SER_RECIP[j];
      q0          = sr_q[j].mq[63:32];
      qi          = q0 * SER_DIV[j];
      rr          = sr_q[j].v - qi;
      q           = (rr >= SER_DIV[j]) ? (q0 + 32'd1) : q0;
      sa_d[j+1].cls = sr_q[j].cls;
      sa_d[j+1].w   = sr_q[j].w;
      sa_d[j+1].n   = sr_q[j].n;
      sa_d[j+1].p   = ONE_Q30 + q;
    end
  end

  always_comb begin
    logic [4:0]  shamt;
    logic [31:0] sh;
    shamt = 5'd15 + sa_q[SER_TERMS].n;
    sh    = sa_q[SER_TERMS].p >> shamt;
    unique case (sa_q[SER_TERMS].cls)
      CLS_FULL: inten_d = 17'h10000;
      CLS_FALL: inten_d = sh[16:0];
      default:  inten_d = '0;
    endcase
  end

  always_comb begin
    logic [40:0] t;
    lvl_d[0] = cfg_i.red_level * inten_q;
    lvl_d[1] = cfg_i.green_level * inten_q;
    lvl_d[2] = cfg_i.blue_level * inten_q;
    for (int c = 0; c < 3; c++) begin
      t        = {lvl_q[c], 8'b0} - {8'b0, lvl_q[c]} + 41'h0_8000_0000;
      rgb_d[c] = t[40] ? 8'hFF : t[39:32];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NTOT-2:0], valid_i & entry_ok};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xy_q[0] <= item_i;
      for (int i = 1; i < NTOT; i++) begin
        xy_q[i] <= xy_q[i-1];
      end
      ent_q   <= ent_d;
      d1_q    <= d1_d;
      sq_q    <= sq_d;
      cl_q    <= cl_d;
      d2_q    <= d2_d;
      cm_q    <= cm_d;
      cs_q    <= cs_d;
      lgs_q   <= lgs_d;
      pr_q    <= pr_d;
      sm_q    <= sm_d;
      sr_q    <= sr_d;
      sa_q    <= sa_d;
      inten_q <= inten_d;
      lvl_q   <= lvl_d;
      rgb_q   <= rgb_d;
    end
  end

  assign valid_o     = v_q[NTOT-1];
  assign res_o.coord = xy_q[NTOT-1];
  assign res_o.red   = rgb_q[0];
  assign res_o.green = rgb_q[1];
  assign res_o.blue  = rgb_q[2];

`ifndef SYNTH
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |-> valid_o)
    else $error("Pipeline held without a finished item at its tail.");

  a_tail_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !en_i) |=> (valid_o && $stable(res_o)))
    else $error("Held tail item changed.");
`endif

endmodule

FILE: rtl/core/sfg_emit.sv
// Output stage: holds one finished item and issues its eight mirrored texel writes.
// Depends on sfg_pkg for the item types and the size helpers.
module sfg_emit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [10:0]        image_size_i,
  input  logic               valid_i,
  input  sfg_pkg::core_res_t res_i,
  output logic               take_o,
  output logic               valid_o,
  input  logic               stall_i,
  output sfg_pkg::out_item_t item_o
);

  localparam logic [2:0] LAST_IDX = 3'd7;

  logic               busy_q, busy_d;
  logic [2:0]         cnt_q, cnt_d;
  sfg_pkg::core_res_t hold_q;
  logic               done;
  logic [10:0]        size;
  logic [9:0]         hw;
  logic [10:0]        tx, ty, txm, tym, col, row;

  assign done   = busy_q && !stall_i && (cnt_q == LAST_IDX);
  assign take_o = !busy_q || done;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (take_o) begin
      busy_d = valid_i;
      cnt_d  = '0;
    end else if (!stall_i) begin
      cnt_d = cnt_q + 3'd1;
    end
  end

  always_comb begin
    size = sfg_pkg::eff_size(image_size_i);
    hw   = sfg_pkg::half_span(size);
    tx   = {2'b0, hold_q.coord.octant_col} + {1'b0, hw};
    ty   = {2'b0, hold_q.coord.octant_row} + {1'b0, hw};
    txm  = size - tx - 11'd1;
    tym  = size - ty - 11'd1;
    if (cnt_q[2]) begin
      col = cnt_q[1] ? tym : ty;
      row = cnt_q[0] ? txm : tx;
    end else begin
      col = cnt_q[1] ? txm : tx;
      row = cnt_q[0] ? tym : ty;
    end
    item_o.texel_col  = col[9:0];
    item_o.texel_row  = row[9:0];
    item_o.red_out    = hold_q.red;
    item_o.green_out  = hold_q.green;
    item_o.blue_out   = hold_q.blue;
    item_o.last_write = (cnt_q == LAST_IDX);
  end

  assign valid_o = busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && valid_i) begin
      hold_q <= res_i;
    end
  end

`ifndef SYNTH
  a_idle_count_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (cnt_q == '0))
    else $error("Write counter moved while no item is held.");

  a_take_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && take_o) |-> (valid_o && !stall_i && item_o.last_write))
    else $error("Held item replaced before its last write left.");

  a_drain_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done && !valid_i) |=> !busy_q)
    else $error("Output stays busy after its last write with nothing queued.");
`endif

endmodule

FILE: rtl/core/spotlight_falloff_texel_gen_top.sv
// Top level of the spotlight falloff texel generator: register file, intensity pipeline, writer.
// Depends on sfg_pkg, sfg_cfg, sfg_core and sfg_emit.
//
//   channel   direction  handshake             payload
//   in        sink       in_valid_i/in_stall_o  in_item_i (octant column and row)
//   out       source     out_valid_o/out_stall_i out_item_o (texel write)
//   config    sink       psel/penable/pwrite    paddr, pwdata, prdata
//
// One new item may enter the intensity pipeline each cycle unless in_stall_o holds it.
// Each item in the octant leaves as eight writes, one per cycle unless out_stall_i holds them,
// so the writer, not the pipeline, bounds the sustained rate; items outside the octant leave nothing.
// Reset clears all valid bits and loads the register defaults; no clearing pass is needed.
// A stall at the output freezes the whole pipeline while a finished item waits at its tail.
module spotlight_falloff_texel_gen_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sfg_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sfg_pkg::out_item_t out_item_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  sfg_pkg::cfg_t      cfg;
  sfg_pkg::core_res_t core_res;
  logic               core_valid;
  logic               take;
  logic               en;

  assign en         = !core_valid || take;
  assign in_stall_o = !en;

  sfg_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sfg_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .item_i  (in_item_i),
    .cfg_i   (cfg),
    .valid_o (core_valid),
    .res_o   (core_res)
  );

  sfg_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .image_size_i (cfg.image_size),
    .valid_i      (core_valid),
    .res_i        (core_res),
    .take_o       (take),
    .valid_o      (out_valid_o),
    .stall_i      (out_stall_i),
    .item_o       (out_item_o)
  );

endmodule
